// ===== design/brc_pkg.sv =====
// ----------------------------------------------------------------------------
// brc_pkg
// Shared types and constants for the blit rectangle clipper.
// ----------------------------------------------------------------------------
package brc_pkg;

    localparam int COORD_W = 16;
    localparam int ARITH_W = 18;
    localparam int CFG_IDX_W = 2;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [ARITH_W-1:0] t_arith;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLIP_LEFT   = 2'd0,
        CFG_CLIP_TOP    = 2'd1,
        CFG_CLIP_RIGHT  = 2'd2,
        CFG_CLIP_BOTTOM = 2'd3
    } t_cfg_idx;

    localparam t_coord CLIP_LEFT_RST   = 16'sd0;
    localparam t_coord CLIP_TOP_RST    = 16'sd0;
    localparam t_coord CLIP_RIGHT_RST  = 16'sd32767;
    localparam t_coord CLIP_BOTTOM_RST = 16'sd32767;

    typedef struct packed {
        t_coord clip_left;
        t_coord clip_top;
        t_coord clip_right;
        t_coord clip_bottom;
    } t_clip_win;

    typedef struct packed {
        logic   func;
        t_coord dest_x;
        t_coord dest_y;
        t_coord dest_extent_x;
        t_coord dest_extent_y;
        t_coord src_x;
        t_coord src_y;
        t_coord src_extent_x;
        t_coord src_extent_y;
    } t_item;

    typedef struct packed {
        logic   rejected;
        t_coord dest_x;
        t_coord dest_y;
        t_coord dest_extent_x;
        t_coord dest_extent_y;
        t_coord src_x;
        t_coord src_y;
        t_coord src_extent_x;
        t_coord src_extent_y;
    } t_result;

    typedef struct packed {
        logic   reject;
        t_coord org;
        t_coord ext;
        t_coord src_org;
        t_coord src_ext;
    } t_axis_out;

    function automatic t_arith sext(input t_coord v);
        return t_arith'({{(ARITH_W-COORD_W){v[COORD_W-1]}}, v});
    endfunction

endpackage

// ===== design/brc_cfg.sv =====
// ----------------------------------------------------------------------------
// brc_cfg
// Clip window registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module brc_cfg import brc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COORD_W-1:0]   i_cfg_data,
    output t_clip_win            o_win
);

    t_clip_win r_win;

    assign o_cfg_ready = 1'b1;
    assign o_win       = r_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.clip_left   <= CLIP_LEFT_RST;
            r_win.clip_top    <= CLIP_TOP_RST;
            r_win.clip_right  <= CLIP_RIGHT_RST;
            r_win.clip_bottom <= CLIP_BOTTOM_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CLIP_LEFT:   r_win.clip_left   <= t_coord'(i_cfg_data);
                CFG_CLIP_TOP:    r_win.clip_top    <= t_coord'(i_cfg_data);
                CFG_CLIP_RIGHT:  r_win.clip_right  <= t_coord'(i_cfg_data);
                CFG_CLIP_BOTTOM: r_win.clip_bottom <= t_coord'(i_cfg_data);
                default: ;
            endcase
        end
    end

endmodule

// ===== design/brc_axis.sv =====
// ----------------------------------------------------------------------------
// brc_axis
// One axis of the clip: extent decode, reject test, far then near edge cut,
// extent rebuild. 18-bit wrapping arithmetic, 16-bit results.
// ----------------------------------------------------------------------------
module brc_axis import brc_pkg::*; (
    input  logic      i_func,
    input  t_coord    i_org,
    input  t_coord    i_ext,
    input  t_coord    i_src_org,
    input  t_coord    i_src_ext,
    input  t_coord    i_lo,
    input  t_coord    i_hi,
    output t_axis_out o_res
);

    t_arith org, src_org, lo, hi, hi1;
    t_arith len, src_len, sum, last;
    t_arith d_hi, len1, src_len1;
    t_arith d_lo, len2, src_len2, org2, src_org2;
    t_arith ext_out, src_ext_out;
    logic   cut_hi, cut_lo;

    always_comb begin
        org     = sext(i_org);
        src_org = sext(i_src_org);
        lo      = sext(i_lo);
        hi      = sext(i_hi);
        hi1     = hi + 18'sd1;

        len     = i_func ? sext(i_ext) - org + 18'sd1 : sext(i_ext);
        src_len = i_func ? sext(i_src_ext) - src_org + 18'sd1 : sext(i_src_ext);

        sum  = org + len;
        last = sum - 18'sd1;

        cut_hi   = sum > hi1;
        d_hi     = sum - hi1;
        len1     = cut_hi ? len - d_hi : len;
        src_len1 = cut_hi ? src_len - d_hi : src_len;

        cut_lo   = org < lo;
        d_lo     = lo - org;
        len2     = cut_lo ? len1 - d_lo : len1;
        src_len2 = cut_lo ? src_len1 - d_lo : src_len1;
        src_org2 = cut_lo ? src_org + d_lo : src_org;
        org2     = cut_lo ? lo : org;

        ext_out     = i_func ? org2 + len2 - 18'sd1 : len2;
        src_ext_out = i_func ? src_org2 + src_len2 - 18'sd1 : src_len2;

        o_res.reject  = (org > hi) || (last < lo);
        o_res.org     = t_coord'(org2[COORD_W-1:0]);
        o_res.ext     = t_coord'(ext_out[COORD_W-1:0]);
        o_res.src_org = t_coord'(src_org2[COORD_W-1:0]);
        o_res.src_ext = t_coord'(src_ext_out[COORD_W-1:0]);
    end

endmodule

// ===== design/blit_rect_clipper.sv =====
// ----------------------------------------------------------------------------
// blit_rect_clipper
// Clips a blit destination rectangle to the clip window and trims the
// source rectangle by the same amounts.
//
//   channel   direction  handshake                   payload
//   input     in         i_valid / o_stall           i_func, i_dest_*, i_src_*
//   result    out        o_valid / i_stall           o_rejected, o_out_*
//   config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One transaction per cycle unless stalled; the input register and result
// register hold it in turn, both axes clipped in the logic between them.
// Synchronous active-low reset empties both registers and loads the default
// window; the config channel is always ready.
// A stalled result holds; the input register still takes a transaction
// while it is empty or the result register is free or being drained.
// ----------------------------------------------------------------------------
module blit_rect_clipper import brc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_func,
    input  t_coord               i_dest_x,
    input  t_coord               i_dest_y,
    input  t_coord               i_dest_extent_x,
    input  t_coord               i_dest_extent_y,
    input  t_coord               i_src_x,
    input  t_coord               i_src_y,
    input  t_coord               i_src_extent_x,
    input  t_coord               i_src_extent_y,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_rejected,
    output t_coord               o_out_dest_x,
    output t_coord               o_out_dest_y,
    output t_coord               o_out_dest_extent_x,
    output t_coord               o_out_dest_extent_y,
    output t_coord               o_out_src_x,
    output t_coord               o_out_src_y,
    output t_coord               o_out_src_extent_x,
    output t_coord               o_out_src_extent_y,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COORD_W-1:0]   i_cfg_data
);

    t_clip_win win;
    t_axis_out ax_x, ax_y;
    logic      r_in_valid, r_out_valid;
    t_item     r_in;
    t_result   r_out, n_out;
    logic      out_adv, in_adv;

    brc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_win       (win)
    );

    brc_axis u_axis_x (
        .i_func    (r_in.func),
        .i_org     (r_in.dest_x),
        .i_ext     (r_in.dest_extent_x),
        .i_src_org (r_in.src_x),
        .i_src_ext (r_in.src_extent_x),
        .i_lo      (win.clip_left),
        .i_hi      (win.clip_right),
        .o_res     (ax_x)
    );

    brc_axis u_axis_y (
        .i_func    (r_in.func),
        .i_org     (r_in.dest_y),
        .i_ext     (r_in.dest_extent_y),
        .i_src_org (r_in.src_y),
        .i_src_ext (r_in.src_extent_y),
        .i_lo      (win.clip_top),
        .i_hi      (win.clip_bottom),
        .o_res     (ax_y)
    );

    assign out_adv = !r_out_valid || !i_stall;
    assign in_adv  = !r_in_valid || out_adv;
    assign o_stall = !in_adv;

    always_comb begin
        n_out.rejected = ax_x.reject || ax_y.reject;
        if (n_out.rejected) begin
            n_out.dest_x        = r_in.dest_x;
            n_out.dest_y        = r_in.dest_y;
            n_out.dest_extent_x = r_in.dest_extent_x;
            n_out.dest_extent_y = r_in.dest_extent_y;
            n_out.src_x         = r_in.src_x;
            n_out.src_y         = r_in.src_y;
            n_out.src_extent_x  = r_in.src_extent_x;
            n_out.src_extent_y  = r_in.src_extent_y;
        end else begin
            n_out.dest_x        = ax_x.org;
            n_out.dest_y        = ax_y.org;
            n_out.dest_extent_x = ax_x.ext;
            n_out.dest_extent_y = ax_y.ext;
            n_out.src_x         = ax_x.src_org;
            n_out.src_y         = ax_y.src_org;
            n_out.src_extent_x  = ax_x.src_ext;
            n_out.src_extent_y  = ax_y.src_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_adv) begin
                r_in_valid <= i_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_valid) begin
            r_in.func          <= i_func;
            r_in.dest_x        <= i_dest_x;
            r_in.dest_y        <= i_dest_y;
            r_in.dest_extent_x <= i_dest_extent_x;
            r_in.dest_extent_y <= i_dest_extent_y;
            r_in.src_x         <= i_src_x;
            r_in.src_y         <= i_src_y;
            r_in.src_extent_x  <= i_src_extent_x;
            r_in.src_extent_y  <= i_src_extent_y;
        end
        if (out_adv && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_rejected          = r_out.rejected;
    assign o_out_dest_x        = r_out.dest_x;
    assign o_out_dest_y        = r_out.dest_y;
    assign o_out_dest_extent_x = r_out.dest_extent_x;
    assign o_out_dest_extent_y = r_out.dest_extent_y;
    assign o_out_src_x         = r_out.src_x;
    assign o_out_src_y         = r_out.src_y;
    assign o_out_src_extent_x  = r_out.src_extent_x;
    assign o_out_src_extent_y  = r_out.src_extent_y;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid)
        else $error("input stalled with empty input register");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_in_valid)
        else $error("accepted transaction lost");

    a_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_adv) |=> o_valid)
        else $error("transaction not forwarded to result register");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blit_rect_clipper testbench
// Drives blit commands into the clipper under several clip windows and
// changing back-pressure. A scoreboard predicts every clipped rectangle
// and checks each result, field by field, in order of arrival.
// ----------------------------------------------------------------------------
module tb import brc_pkg::*; ();

    localparam int HOLD_LEN       = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SEGMENTS       = 10;
    localparam int SEG_ITEMS      = 100;

    class clip_checker;
        t_clip_win win;
        t_result   clipped_q[$];
        int        errors;

        function new();
            win.clip_left   = CLIP_LEFT_RST;
            win.clip_top    = CLIP_TOP_RST;
            win.clip_right  = CLIP_RIGHT_RST;
            win.clip_bottom = CLIP_BOTTOM_RST;
            errors = 0;
        endfunction

        function void load_window_reg(t_cfg_idx idx, t_coord val);
            case (idx)
                CFG_CLIP_LEFT:   win.clip_left   = val;
                CFG_CLIP_TOP:    win.clip_top    = val;
                CFG_CLIP_RIGHT:  win.clip_right  = val;
                CFG_CLIP_BOTTOM: win.clip_bottom = val;
                default: ;
            endcase
        endfunction

        function t_result clip_blit(t_item it);
            t_arith  rx, ry, rw, rh, sx, sy, sw, sh;
            t_arith  cl, ct, cr, cb, one, t, lim, d;
            t_result res;
            logic    rej;
            one = 18'sd1;
            cl = sext(win.clip_left);
            ct = sext(win.clip_top);
            cr = sext(win.clip_right);
            cb = sext(win.clip_bottom);
            rx = sext(it.dest_x);
            ry = sext(it.dest_y);
            rw = sext(it.dest_extent_x);
            rh = sext(it.dest_extent_y);
            sx = sext(it.src_x);
            sy = sext(it.src_y);
            sw = sext(it.src_extent_x);
            sh = sext(it.src_extent_y);
            if (it.func) begin
                rw = rw - rx + one;
                rh = rh - ry + one;
                sw = sw - sx + one;
                sh = sh - sy + one;
            end
            rej = 1'b0;
            if (rx > cr || ry > cb) rej = 1'b1;
            t = rx + rw - one;
            if (t < cl) rej = 1'b1;
            t = ry + rh - one;
            if (t < ct) rej = 1'b1;
            if (rej) begin
                res.rejected      = 1'b1;
                res.dest_x        = it.dest_x;
                res.dest_y        = it.dest_y;
                res.dest_extent_x = it.dest_extent_x;
                res.dest_extent_y = it.dest_extent_y;
                res.src_x         = it.src_x;
                res.src_y         = it.src_y;
                res.src_extent_x  = it.src_extent_x;
                res.src_extent_y  = it.src_extent_y;
                return res;
            end
            // right, left, bottom, top
            t = rx + rw;
            lim = cr + one;
            if (t > lim) begin
                d = t - lim;
                rw = rw - d;
                sw = sw - d;
            end
            if (rx < cl) begin
                d = cl - rx;
                sw = sw - d;
                sx = sx + d;
                rw = rw - d;
                rx = cl;
            end
            t = ry + rh;
            lim = cb + one;
            if (t > lim) begin
                d = t - lim;
                rh = rh - d;
                sh = sh - d;
            end
            if (ry < ct) begin
                d = ct - ry;
                sh = sh - d;
                sy = sy + d;
                rh = rh - d;
                ry = ct;
            end
            if (it.func) begin
                rw = rx + rw - one;
                rh = ry + rh - one;
                sw = sx + sw - one;
                sh = sy + sh - one;
            end
            res.rejected      = 1'b0;
            res.dest_x        = rx[COORD_W-1:0];
            res.dest_y        = ry[COORD_W-1:0];
            res.dest_extent_x = rw[COORD_W-1:0];
            res.dest_extent_y = rh[COORD_W-1:0];
            res.src_x         = sx[COORD_W-1:0];
            res.src_y         = sy[COORD_W-1:0];
            res.src_extent_x  = sw[COORD_W-1:0];
            res.src_extent_y  = sh[COORD_W-1:0];
            return res;
        endfunction

        function void note_item(t_item it);
            clipped_q.push_back(clip_blit(it));
        endfunction

        function int pending();
            return clipped_q.size();
        endfunction

        function void cmp(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0d actual %0d",
                         $time, name, $signed(want), $signed(got));
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (clipped_q.size() == 0) begin
                $display("%0t: result with nothing expected, expected none actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = clipped_q.pop_front();
            cmp("rejected", 16'(want.rejected), 16'(got.rejected));
            cmp("out_dest_x", want.dest_x, got.dest_x);
            cmp("out_dest_y", want.dest_y, got.dest_y);
            cmp("out_dest_extent_x", want.dest_extent_x, got.dest_extent_x);
            cmp("out_dest_extent_y", want.dest_extent_y, got.dest_extent_y);
            cmp("out_src_x", want.src_x, got.src_x);
            cmp("out_src_y", want.src_y, got.src_y);
            cmp("out_src_extent_x", want.src_extent_x, got.src_extent_x);
            cmp("out_src_extent_y", want.src_extent_y, got.src_extent_y);
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic                 i_func = 1'b0;
    t_coord               i_dest_x = '0;
    t_coord               i_dest_y = '0;
    t_coord               i_dest_extent_x = '0;
    t_coord               i_dest_extent_y = '0;
    t_coord               i_src_x = '0;
    t_coord               i_src_y = '0;
    t_coord               i_src_extent_x = '0;
    t_coord               i_src_extent_y = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic                 o_rejected;
    t_coord               o_out_dest_x;
    t_coord               o_out_dest_y;
    t_coord               o_out_dest_extent_x;
    t_coord               o_out_dest_extent_y;
    t_coord               o_out_src_x;
    t_coord               o_out_src_y;
    t_coord               o_out_src_extent_x;
    t_coord               o_out_src_extent_y;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [COORD_W-1:0]   i_cfg_data = '0;

    clip_checker sb = new();

    int send_idle_pct = 32;
    int recv_idle_pct = 61;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int idle_cycles = 0;

    blit_rect_clipper u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_func              (i_func),
        .i_dest_x            (i_dest_x),
        .i_dest_y            (i_dest_y),
        .i_dest_extent_x     (i_dest_extent_x),
        .i_dest_extent_y     (i_dest_extent_y),
        .i_src_x             (i_src_x),
        .i_src_y             (i_src_y),
        .i_src_extent_x      (i_src_extent_x),
        .i_src_extent_y      (i_src_extent_y),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_rejected          (o_rejected),
        .o_out_dest_x        (o_out_dest_x),
        .o_out_dest_y        (o_out_dest_y),
        .o_out_dest_extent_x (o_out_dest_extent_x),
        .o_out_dest_extent_y (o_out_dest_extent_y),
        .o_out_src_x         (o_out_src_x),
        .o_out_src_y         (o_out_src_y),
        .o_out_src_extent_x  (o_out_src_extent_x),
        .o_out_src_extent_y  (o_out_src_extent_y),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result side: check, then decide the stall for the next cycle
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.rejected      = o_rejected;
            got.dest_x        = o_out_dest_x;
            got.dest_y        = o_out_dest_y;
            got.dest_extent_x = o_out_dest_extent_x;
            got.dest_extent_y = o_out_dest_extent_y;
            got.src_x         = o_out_src_x;
            got.src_y         = o_out_src_y;
            got.src_extent_x  = o_out_src_extent_x;
            got.src_extent_y  = o_out_src_extent_y;
            sb.check_result(got);
        end
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("blit_rect_clipper test failed");
            $finish;
        end
    end

    task automatic send_item(t_item it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_func          <= it.func;
        i_dest_x        <= it.dest_x;
        i_dest_y        <= it.dest_y;
        i_dest_extent_x <= it.dest_extent_x;
        i_dest_extent_y <= it.dest_extent_y;
        i_src_x         <= it.src_x;
        i_src_y         <= it.src_y;
        i_src_extent_x  <= it.src_extent_x;
        i_src_extent_y  <= it.src_extent_y;
        i_valid         <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        sb.note_item(it);
    endtask

    task automatic send_rect(int f, int dx, int dy, int dw, int dh,
                             int sx, int sy, int sw, int sh);
        t_item it;
        it.func          = 1'(f);
        it.dest_x        = t_coord'(dx);
        it.dest_y        = t_coord'(dy);
        it.dest_extent_x = t_coord'(dw);
        it.dest_extent_y = t_coord'(dh);
        it.src_x         = t_coord'(sx);
        it.src_y         = t_coord'(sy);
        it.src_extent_x  = t_coord'(sw);
        it.src_extent_y  = t_coord'(sh);
        send_item(it);
    endtask

    // drop valid and hold until every transaction has come out
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_window(int l, int t, int r, int b);
        t_cfg_idx idx_list[4];
        t_coord   vals[4];
        idx_list = '{CFG_CLIP_LEFT, CFG_CLIP_TOP, CFG_CLIP_RIGHT, CFG_CLIP_BOTTOM};
        vals = '{t_coord'(l), t_coord'(t), t_coord'(r), t_coord'(b)};
        for (int k = 0; k < 4; k++) begin
            i_cfg_index <= idx_list[k];
            i_cfg_data  <= vals[k];
            i_cfg_valid <= 1'b1;
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.load_window_reg(idx_list[k], vals[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_coord pick_extreme();
        case ($urandom_range(4))
            0: return t_coord'(16'h8000);
            1: return t_coord'(16'h7fff);
            2: return t_coord'(16'h0000);
            3: return t_coord'(16'hffff);
            default: return t_coord'(16'h0001);
        endcase
    endfunction

    function automatic t_coord pick_coord(t_coord lo, t_coord hi);
        case ($urandom_range(9))
            0: return t_coord'($urandom);
            1: return pick_extreme();
            2, 3, 4, 5: return t_coord'(lo + $urandom_range(0, 400) - 200);
            default: return t_coord'(hi + $urandom_range(0, 400) - 200);
        endcase
    endfunction

    function automatic t_coord pick_size();
        case ($urandom_range(9))
            0: return t_coord'($urandom);
            1: return pick_extreme();
            default: return t_coord'($urandom_range(1, 600));
        endcase
    endfunction

    function automatic t_coord pick_src();
        case ($urandom_range(7))
            0: return t_coord'($urandom);
            1: return pick_extreme();
            default: return t_coord'($urandom_range(0, 2000));
        endcase
    endfunction

    function automatic t_item make_item(t_clip_win w);
        t_item  it;
        t_coord dw, dh, sw, sh;
        if ($urandom_range(9) == 0) begin
            it.func          = 1'($urandom_range(1));
            it.dest_x        = t_coord'($urandom);
            it.dest_y        = t_coord'($urandom);
            it.dest_extent_x = t_coord'($urandom);
            it.dest_extent_y = t_coord'($urandom);
            it.src_x         = t_coord'($urandom);
            it.src_y         = t_coord'($urandom);
            it.src_extent_x  = t_coord'($urandom);
            it.src_extent_y  = t_coord'($urandom);
            return it;
        end
        it.func   = 1'($urandom_range(1));
        it.dest_x = pick_coord(w.clip_left, w.clip_right);
        it.dest_y = pick_coord(w.clip_top, w.clip_bottom);
        it.src_x  = pick_src();
        it.src_y  = pick_src();
        dw = pick_size();
        dh = pick_size();
        sw = ($urandom_range(3) == 0) ? pick_size() : dw;
        sh = ($urandom_range(3) == 0) ? pick_size() : dh;
        if (it.func) begin
            it.dest_extent_x = t_coord'(it.dest_x + dw - 1);
            it.dest_extent_y = t_coord'(it.dest_y + dh - 1);
            it.src_extent_x  = t_coord'(it.src_x + sw - 1);
            it.src_extent_y  = t_coord'(it.src_y + sh - 1);
        end else begin
            it.dest_extent_x = dw;
            it.dest_extent_y = dh;
            it.src_extent_x  = sw;
            it.src_extent_y  = sh;
        end
        return it;
    endfunction

    task automatic new_window(int seg);
        int l, t, r, b;
        l = int'($urandom_range(0, 600)) - 300;
        t = int'($urandom_range(0, 600)) - 300;
        r = l + int'($urandom_range(0, 500));
        b = t + int'($urandom_range(0, 500));
        case (seg)
            1: begin
                l = -32768; t = -32768; r = 32767; b = 32767;
            end
            3: begin
                r = l - 1 - int'($urandom_range(0, 300));
                b = t - 1 - int'($urandom_range(0, 300));
            end
            4: begin
                r = l; b = t;
            end
            6: begin
                l = -32768; t = -32768; r = -32768; b = -32768;
            end
            8: begin
                l = 32767; t = 32767; r = 32767; b = 32767;
            end
            default: ;
        endcase
        write_window(l, t, r, b);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default window after reset
        send_rect(0, 0, 0, 10, 10, 5, 5, 10, 10);
        send_rect(0, -5, -5, 20, 20, 0, 0, 20, 20);
        send_rect(0, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        send_rect(0, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        send_rect(1, 0, 0, 9, 9, 0, 0, 9, 9);
        send_rect(1, -32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
        wait_idle();

        write_window(10, 20, 100, 200);
        send_rect(0, 101, 50, 5, 5, 0, 0, 5, 5);
        send_rect(0, 50, 201, 5, 5, 0, 0, 5, 5);
        send_rect(0, 0, 50, 10, 5, 0, 0, 10, 5);
        send_rect(0, 50, 0, 5, 20, 0, 0, 5, 20);
        send_rect(0, 100, 200, 1, 1, 7, 7, 1, 1);
        send_rect(0, 0, 0, 11, 21, 3, 4, 11, 21);
        send_rect(0, 0, 0, 300, 400, 1000, 2000, 300, 400);
        send_rect(1, 0, 0, 299, 399, 1000, 2000, 1299, 2399);
        send_rect(0, 50, 50, 0, 5, 0, 0, 0, 5);
        send_rect(0, 50, 50, -3, 5, 0, 0, -3, 5);
        send_rect(1, 60, 60, 40, 40, 10, 10, 5, 5);
        send_rect(0, 50, 50, 5, 5, 32767, -32768, 32767, -32768);
        send_rect(1, 5, 15, 32767, 32767, -1, -1, -32768, 32767);
        wait_idle();

        // inverted window
        write_window(100, 100, -100, -100);
        send_rect(0, 0, 0, 50, 50, 0, 0, 50, 50);
        send_rect(0, -200, -200, 500, 500, 0, 0, 500, 500);
        send_rect(1, -200, -200, 300, 300, 0, 0, 500, 500);
        wait_idle();

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg < 4) begin
                send_idle_pct = 32;
                recv_idle_pct = 61;
            end else if (seg < 7) begin
                send_idle_pct = 61;
                recv_idle_pct = 32;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            new_window(seg);
            if (seg == 2 || seg == 7) hold_req++;
            for (int n = 0; n < SEG_ITEMS; n++)
                send_item(make_item(sb.win));
            wait_idle();
        end

        repeat (4) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("blit_rect_clipper test passed");
        end else begin
            $display("blit_rect_clipper test failed");
        end
        $finish;
    end

endmodule

// ===== blit_rect_clipper.f =====
design/brc_pkg.sv
design/brc_cfg.sv
design/brc_axis.sv
design/blit_rect_clipper.sv
tb/sv/tb.sv
